// ===== src/ansi_escape_terminal_engine_assert.svh =====
// assertion macros for the terminal escape engine
`ifndef ANSI_ESCAPE_TERMINAL_ENGINE_ASSERT_SVH
`define ANSI_ESCAPE_TERMINAL_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define ATE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ATE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATE_ASSERT(lbl, prop, msg)
`define ATE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== src/ate_pkg.sv =====
// shared types, codes and constants of the terminal escape engine
package ate_pkg;

  localparam int MAX_PARAMS = 16;
  localparam int PIW = $clog2(MAX_PARAMS);
  localparam int PARAM_W = 14;
  localparam logic [PARAM_W-1:0] PARAM_SAT = 14'd9999;
  localparam int TDATA_W = 72;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;
  localparam logic [1:0] CFG_BASE    = 2'd2;
  localparam logic [1:0] CFG_COLOR   = 2'd3;

  localparam int FL_SMALL  = 0;
  localparam int FL_NOWRAP = 1;
  localparam int FL_HIDE   = 2;
  localparam int FL_BRIGHT = 3;
  localparam int FL_DIM    = 4;
  localparam int FL_PASS   = 5;

  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL_UP = 8'h80;
  localparam logic [7:0] CH_CSI    = 8'h9B;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_B   = 8'h42;
  localparam logic [7:0] CH_UC_C   = 8'h43;
  localparam logic [7:0] CH_UC_D   = 8'h44;
  localparam logic [7:0] CH_UC_E   = 8'h45;
  localparam logic [7:0] CH_UC_H   = 8'h48;
  localparam logic [7:0] CH_UC_J   = 8'h4A;
  localparam logic [7:0] CH_UC_K   = 8'h4B;
  localparam logic [7:0] CH_UC_M   = 8'h4D;
  localparam logic [7:0] CH_LC_C   = 8'h63;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_H   = 8'h68;
  localparam logic [7:0] CH_LC_L   = 8'h6C;
  localparam logic [7:0] CH_LC_M   = 8'h6D;
  localparam logic [7:0] CH_LC_S   = 8'h73;
  localparam logic [7:0] CH_LC_U   = 8'h75;

  localparam logic [PARAM_W-1:0] MODE_COLUMN = 14'd3;
  localparam logic [PARAM_W-1:0] MODE_WRAP   = 14'd7;
  localparam logic [PARAM_W-1:0] MODE_CURSOR = 14'd25;

  typedef enum logic [1:0] {
    PM_NORMAL,
    PM_ESC,
    PM_CSI
  } parser_mode_t;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_CLEAR,
    CMD_SCROLL_UP,
    CMD_SCROLL_DOWN,
    CMD_BELL,
    CMD_FONT,
    CMD_COLUMN
  } command_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SGR,
    ST_MUL,
    ST_ADD,
    ST_SEND
  } ctrl_state_t;

  typedef struct packed {
    logic       exec;
    logic       sgr_step;
    logic       mul;
    logic       add;
    logic [1:0] job;
    logic       send_idx;
  } ctl_t;

  typedef struct packed {
    logic [1:0] nres;
    logic       sgr;
    logic       sgr_last;
  } sts_t;

  typedef struct packed {
    command_t   cmd;
    logic [7:0] color;
    logic [7:0] chr;
    logic       font;
    logic       wide;
    logic       zaddr;
    logic       swap;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] ex;
    logic [7:0] ey;
  } slot_t;

  function automatic slot_t mk_slot(command_t c, logic [7:0] color, logic [7:0] chr,
                                    logic font, logic wide, logic zaddr,
                                    logic [7:0] sx, logic [7:0] sy,
                                    logic [7:0] ex, logic [7:0] ey);
    slot_t s;
    s.cmd = c;
    s.color = color;
    s.chr = chr;
    s.font = font;
    s.wide = wide;
    s.zaddr = zaddr;
    s.swap = (c == CMD_CLEAR);
    s.sx = sx;
    s.sy = sy;
    s.ex = ex;
    s.ey = ey;
    return s;
  endfunction

endpackage

// ===== src/ate_ctrl.sv =====
// controller state machine sequencing parse, attribute walk, address and output phases
`include "ansi_escape_terminal_engine_assert.svh"
module ate_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_last,
  input  ate_pkg::sts_t sts,
  output ate_pkg::ctl_t ctl
);

  ate_pkg::ctrl_state_t state, state_next;
  logic [1:0] job, job_next;
  logic       send_idx, send_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ate_pkg::ST_IDLE;
      job <= '0;
      send_idx <= 1'b0;
    end else begin
      state <= state_next;
      job <= job_next;
      send_idx <= send_idx_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next = job;
    send_idx_next = send_idx;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_last = (send_idx == (sts.nres[1] ? 1'b1 : 1'b0));
    ctl = '0;
    ctl.job = job;
    ctl.send_idx = send_idx;
    unique case (state)
      ate_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.exec = 1'b1;
          state_next = ate_pkg::ST_DECIDE;
        end
      end
      ate_pkg::ST_DECIDE: begin
        job_next = '0;
        send_idx_next = 1'b0;
        if (sts.sgr) state_next = ate_pkg::ST_SGR;
        else if (sts.nres != 2'd0) state_next = ate_pkg::ST_MUL;
        else state_next = ate_pkg::ST_IDLE;
      end
      ate_pkg::ST_SGR: begin
        ctl.sgr_step = 1'b1;
        if (sts.sgr_last) state_next = ate_pkg::ST_IDLE;
      end
      ate_pkg::ST_MUL: begin
        ctl.mul = 1'b1;
        state_next = ate_pkg::ST_ADD;
      end
      ate_pkg::ST_ADD: begin
        ctl.add = 1'b1;
        if (job == {sts.nres[1], 1'b1}) state_next = ate_pkg::ST_SEND;
        else begin
          job_next = job + 2'd1;
          state_next = ate_pkg::ST_MUL;
        end
      end
      ate_pkg::ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (out_last) state_next = ate_pkg::ST_IDLE;
          else send_idx_next = 1'b1;
        end
      end
      default: state_next = ate_pkg::ST_IDLE;
    endcase
  end

  `ATE_ASSERT_RST(a_reset_idle, rst |=> (state == ate_pkg::ST_IDLE), "not idle after reset")
  `ATE_ASSERT(a_sides_apart, !(in_ready && out_valid), "input taken while result shown")
  `ATE_ASSERT(a_send_has_result, (state == ate_pkg::ST_SEND) |-> (sts.nres != 2'd0), "send with no result")
  `ATE_ASSERT(a_last_ends, (out_valid && out_ready && out_last) |=> (state == ate_pkg::ST_IDLE), "last transfer did not end item")

endmodule

// ===== src/ate_dp.sv =====
// datapath: parser state, cursor, attributes, parameters, address unit and result slots
module ate_dp (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_byte,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  ate_pkg::ctl_t ctl,
  output ate_pkg::sts_t sts,
  output logic [2:0]    command,
  output logic [15:0]   range_start,
  output logic [15:0]   range_end,
  output logic [7:0]    cell_color,
  output logic [7:0]    cell_char,
  output logic          small_font,
  output logic          wide_columns,
  output logic [7:0]    cursor_x,
  output logic [7:0]    cursor_y,
  output logic          cursor_hidden
);

  localparam int PIW = ate_pkg::PIW;
  localparam int PW = ate_pkg::PARAM_W;

  logic [7:0]  cols, defc;
  logic [6:0]  rows;
  logic [15:0] base;
  ate_pkg::parser_mode_t pmode;
  logic [7:0]  col, row, scol, srow, color, inter;
  logic        wrap, swrap;
  logic [5:0]  flags;
  logic [PW-1:0] params [ate_pkg::MAX_PARAMS];
  logic [PIW-1:0] pcount, sgr_i, sgr_n;
  logic        sgr_pend;
  logic [1:0]  nres;
  ate_pkg::slot_t slots [2];
  logic [15:0] addr_s [2];
  logic [15:0] addr_e [2];
  logic [15:0] prod;

  logic [7:0] nc, ncm1, nrm1, nr;
  assign nc = (cols == 8'd0) ? 8'd1 : cols;
  assign nr = (rows == 7'd0) ? 8'd1 : {1'b0, rows};
  assign ncm1 = nc - 8'd1;
  assign nrm1 = nr - 8'd1;

  // config write with cursor clamp
  logic [7:0] c_cols, c_nc, c_nr, c_col, c_row;
  logic [6:0] c_rows;
  logic       c_wrap;
  always_comb begin
    c_cols = (cfg_index == ate_pkg::CFG_COLUMNS) ? cfg_data[7:0] : cols;
    c_rows = (cfg_index == ate_pkg::CFG_ROWS) ? cfg_data[6:0] : rows;
    c_nc = (c_cols == 8'd0) ? 8'd1 : c_cols;
    c_nr = (c_rows == 7'd0) ? 8'd1 : {1'b0, c_rows};
    c_col = col;
    c_row = row;
    c_wrap = wrap;
    if (col >= c_nc) begin
      c_col = c_nc - 8'd1;
      c_wrap = 1'b0;
    end
    if (row >= c_nr) c_row = c_nr - 8'd1;
  end

  // parameter read port
  logic [PIW-1:0] rd_idx, pidx;
  logic [PW-1:0]  rd;
  assign pidx = (pcount == '0) ? '0 : pcount - PIW'(1);
  assign rd_idx = ctl.sgr_step ? sgr_i : pidx;
  assign rd = params[rd_idx];

  // byte handling
  ate_pkg::parser_mode_t pm_n;
  logic [7:0] cx, cy, sc_n, sr_n, clr_n, ib_n;
  logic       wr_n, sw_n, pclr, pwe, sgr_go;
  logic [5:0] fl_n;
  logic [PIW-1:0] pc_n;
  logic [PW-1:0]  pval;
  logic [1:0] ne;
  ate_pkg::slot_t es [2];

  always_comb begin
    logic [7:0]  b, code;
    logic        do_ctl, ok;
    logic [8:0]  x, y;
    logic [9:0]  x8;
    logic [17:0] dv;
    logic [PIW:0] pinc;
    logic [PW-1:0] nz, num, v0, v1;
    logic [14:0] sum;
    b = in_byte;
    code = b;
    do_ctl = 1'b0;
    ok = 1'b1;
    x = '0;
    y = '0;
    x8 = '0;
    dv = '0;
    pinc = '0;
    sum = '0;
    nz = params[0];
    num = (nz == '0) ? PW'(1) : nz;
    v0 = (params[0] == '0) ? PW'(1) : params[0];
    v1 = (params[1] == '0) ? PW'(1) : params[1];
    pm_n = pmode;
    cx = col;
    cy = row;
    wr_n = wrap;
    sc_n = scol;
    sr_n = srow;
    sw_n = swrap;
    clr_n = color;
    fl_n = flags;
    ib_n = inter;
    pc_n = pcount;
    pclr = 1'b0;
    pwe = 1'b0;
    pval = '0;
    sgr_go = 1'b0;
    ne = 2'd0;
    es[0] = '0;
    es[1] = '0;
    if (b == ate_pkg::CH_ESC || b == ate_pkg::CH_CSI) begin
      pm_n = (b == ate_pkg::CH_ESC) ? ate_pkg::PM_ESC : ate_pkg::PM_CSI;
      ib_n = '0;
      pc_n = '0;
      pclr = 1'b1;
    end else begin
      case (pmode)
        ate_pkg::PM_NORMAL: begin
          if ((b < ate_pkg::CH_SPACE || b >= ate_pkg::CH_DEL_UP) && !flags[ate_pkg::FL_PASS])
            do_ctl = 1'b1;
          else begin
            if (wr_n) begin
              cx = '0;
              if ({1'b0, cy} + 9'd1 >= {1'b0, nr}) begin
                es[ne[0]] = ate_pkg::mk_slot(ate_pkg::CMD_SCROLL_UP, clr_n, ate_pkg::CH_SPACE,
                                             1'b0, 1'b0, 1'b0, 8'd0, 8'd0, ncm1, nrm1);
                ne = ne + 2'd1;
                cy = nrm1;
              end else cy = cy + 8'd1;
              wr_n = 1'b0;
            end
            es[ne[0]] = ate_pkg::mk_slot(ate_pkg::CMD_WRITE, clr_n, b, 1'b0, 1'b0, 1'b0,
                                         cx, cy, cx, cy);
            ne = ne + 2'd1;
            if ({1'b0, cx} + 9'd1 < {1'b0, nc}) cx = cx + 8'd1;
            else begin
              cx = ncm1;
              wr_n = !flags[ate_pkg::FL_NOWRAP];
            end
          end
        end
        ate_pkg::PM_ESC: begin
          pm_n = ate_pkg::PM_NORMAL;
          case (b)
            ate_pkg::CH_LC_C: begin
              fl_n = '0;
              clr_n = defc;
              es[0] = ate_pkg::mk_slot(ate_pkg::CMD_FONT, defc, ate_pkg::CH_SPACE, 1'b0, 1'b0,
                                       1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
              es[1] = ate_pkg::mk_slot(ate_pkg::CMD_CLEAR, defc, ate_pkg::CH_SPACE, 1'b0, 1'b0,
                                       1'b0, 8'd0, 8'd0, ncm1, nrm1);
              ne = 2'd2;
              cx = '0;
              cy = '0;
              wr_n = 1'b0;
            end
            ate_pkg::CH_SEVEN: begin
              sc_n = cx;
              sr_n = cy;
              sw_n = wr_n;
            end
            ate_pkg::CH_EIGHT: begin
              cx = scol;
              cy = srow;
              wr_n = swrap;
            end
            ate_pkg::CH_LPAREN, ate_pkg::CH_RPAREN: begin
              fl_n[ate_pkg::FL_SMALL] = (b == ate_pkg::CH_RPAREN);
              clr_n = defc;
              es[0] = ate_pkg::mk_slot(ate_pkg::CMD_FONT, defc, ate_pkg::CH_SPACE,
                                       (b == ate_pkg::CH_RPAREN), 1'b0, 1'b1,
                                       8'd0, 8'd0, 8'd0, 8'd0);
              ne = 2'd1;
            end
            ate_pkg::CH_LBRACK: begin
              pm_n = ate_pkg::PM_CSI;
              ib_n = '0;
              pc_n = '0;
              pclr = 1'b1;
            end
            ate_pkg::CH_UC_D: begin
              do_ctl = 1'b1;
              code = ate_pkg::CH_LF;
            end
            ate_pkg::CH_UC_M: begin
              do_ctl = 1'b1;
              code = ate_pkg::CH_VT;
            end
            ate_pkg::CH_UC_E: begin
              wr_n = 1'b0;
              cx = '0;
              if ({1'b0, cy} + 9'd1 >= {1'b0, nr}) begin
                cy = nrm1;
                es[0] = ate_pkg::mk_slot(ate_pkg::CMD_SCROLL_UP, clr_n, ate_pkg::CH_SPACE,
                                         1'b0, 1'b0, 1'b0, 8'd0, 8'd0, ncm1, nrm1);
                ne = 2'd1;
              end else cy = cy + 8'd1;
            end
            default: ;
          endcase
        end
        ate_pkg::PM_CSI: begin
          if (b[7:4] == 4'h2) ib_n = b;
          else if (b[7:4] == 4'h3) begin
            if (b <= ate_pkg::CH_NINE) begin
              if (pcount == '0) pc_n = PIW'(1);
              dv = {1'b0, rd, 3'b0} + {3'b0, rd, 1'b0} + {14'b0, b[3:0]};
              pval = (dv > {4'b0, ate_pkg::PARAM_SAT}) ? ate_pkg::PARAM_SAT : dv[PW-1:0];
              pwe = 1'b1;
            end else if (b == ate_pkg::CH_SEMI) begin
              pinc = (pcount == '0) ? (PIW+1)'(2) : {1'b0, pcount} + (PIW+1)'(1);
              if (pinc >= (PIW+1)'(ate_pkg::MAX_PARAMS))
                pc_n = PIW'(ate_pkg::MAX_PARAMS - 1);
              else pc_n = pinc[PIW-1:0];
            end else if (b == ate_pkg::CH_QUEST) ib_n = b;
          end else if (b[7:4] >= 4'h4) begin
            pm_n = ate_pkg::PM_NORMAL;
            case (b)
              ate_pkg::CH_LC_F, ate_pkg::CH_UC_H: begin
                cy = (v0 > {6'b0, nr}) ? nrm1 : 8'(v0 - PW'(1));
                cx = (v1 > {6'b0, nc}) ? ncm1 : 8'(v1 - PW'(1));
                wr_n = 1'b0;
              end
              ate_pkg::CH_LC_H, ate_pkg::CH_LC_L: begin
                if (inter == ate_pkg::CH_QUEST) begin
                  if (num == ate_pkg::MODE_COLUMN) begin
                    clr_n = defc;
                    cx = '0;
                    cy = '0;
                    wr_n = 1'b0;
                    es[0] = ate_pkg::mk_slot(ate_pkg::CMD_COLUMN, defc, ate_pkg::CH_SPACE,
                                             1'b0, (b == ate_pkg::CH_LC_H), 1'b1,
                                             8'd0, 8'd0, 8'd0, 8'd0);
                    ne = 2'd1;
                  end else if (num == ate_pkg::MODE_WRAP) begin
                    if (b == ate_pkg::CH_LC_L) fl_n[ate_pkg::FL_NOWRAP] = 1'b1;
                    else begin
                      fl_n[ate_pkg::FL_NOWRAP] = 1'b0;
                      if (cx >= ncm1) wr_n = 1'b1;
                    end
                  end else if (num == ate_pkg::MODE_CURSOR) begin
                    fl_n[ate_pkg::FL_HIDE] = (b == ate_pkg::CH_LC_L);
                  end
                end
              end
              ate_pkg::CH_LC_S: begin
                sc_n = cx;
                sr_n = cy;
                sw_n = wr_n;
              end
              ate_pkg::CH_LC_U: begin
                cx = scol;
                cy = srow;
                wr_n = swrap;
              end
              ate_pkg::CH_UC_A: begin
                cy = (num > {6'b0, cy}) ? 8'd0 : cy - num[7:0];
                wr_n = 1'b0;
              end
              ate_pkg::CH_UC_B: begin
                sum = {7'b0, cy} + {1'b0, num};
                cy = (sum >= {7'b0, nr}) ? nrm1 : sum[7:0];
                wr_n = 1'b0;
              end
              ate_pkg::CH_UC_C: begin
                sum = {7'b0, cx} + {1'b0, num};
                cx = (sum >= {7'b0, nc}) ? ncm1 : sum[7:0];
                wr_n = 1'b0;
              end
              ate_pkg::CH_UC_D: begin
                cx = (num > {6'b0, cx}) ? 8'd0 : cx - num[7:0];
                wr_n = 1'b0;
              end
              ate_pkg::CH_UC_K: begin
                if (nz == PW'(0)) begin
                  es[0] = ate_pkg::mk_slot(ate_pkg::CMD_CLEAR, clr_n, ate_pkg::CH_SPACE, 1'b0,
                                           1'b0, 1'b0, cx, cy, ncm1, cy);
                  ne = 2'd1;
                end else if (nz == PW'(1)) begin
                  es[0] = ate_pkg::mk_slot(ate_pkg::CMD_CLEAR, clr_n, ate_pkg::CH_SPACE, 1'b0,
                                           1'b0, 1'b0, 8'd0, cy, cx, cy);
                  ne = 2'd1;
                end else if (nz == PW'(2)) begin
                  es[0] = ate_pkg::mk_slot(ate_pkg::CMD_CLEAR, clr_n, ate_pkg::CH_SPACE, 1'b0,
                                           1'b0, 1'b0, 8'd0, cy, ncm1, cy);
                  ne = 2'd1;
                end
              end
              ate_pkg::CH_UC_J: begin
                if (nz == PW'(0)) begin
                  es[0] = ate_pkg::mk_slot(ate_pkg::CMD_CLEAR, clr_n, ate_pkg::CH_SPACE, 1'b0,
                                           1'b0, 1'b0, cx, cy, ncm1, nrm1);
                  ne = 2'd1;
                end else if (nz == PW'(1)) begin
                  es[0] = ate_pkg::mk_slot(ate_pkg::CMD_CLEAR, clr_n, ate_pkg::CH_SPACE, 1'b0,
                                           1'b0, 1'b0, 8'd0, 8'd0, cx, cy);
                  ne = 2'd1;
                end else if (nz == PW'(2)) begin
                  es[0] = ate_pkg::mk_slot(ate_pkg::CMD_CLEAR, clr_n, ate_pkg::CH_SPACE, 1'b0,
                                           1'b0, 1'b0, 8'd0, 8'd0, ncm1, nrm1);
                  ne = 2'd1;
                  cx = '0;
                  cy = '0;
                  wr_n = 1'b0;
                end
              end
              ate_pkg::CH_LC_M: sgr_go = 1'b1;
              default: ;
            endcase
          end else pm_n = ate_pkg::PM_NORMAL;
        end
        default: pm_n = ate_pkg::PM_NORMAL;
      endcase
    end

    if (do_ctl) begin
      x = {1'b0, cx};
      y = {1'b0, cy};
      case (code)
        ate_pkg::CH_BEL: begin
          es[0] = ate_pkg::mk_slot(ate_pkg::CMD_BELL, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1,
                                   8'd0, 8'd0, 8'd0, 8'd0);
          ne = 2'd1;
          ok = 1'b0;
        end
        ate_pkg::CH_BS: if (x != 9'd0) x = x - 9'd1;
        ate_pkg::CH_HT: begin
          x = {x[8:3], 3'b0} + 9'd8;
          x8 = {1'b0, x} + 10'd8;
          if (x8 > {2'b0, nc}) begin
            x = '0;
            y = y + 9'd1;
          end
        end
        ate_pkg::CH_LF: y = y + 9'd1;
        ate_pkg::CH_VT: begin
          if (y == 9'd0) begin
            es[0] = ate_pkg::mk_slot(ate_pkg::CMD_SCROLL_DOWN, clr_n, ate_pkg::CH_SPACE, 1'b0,
                                     1'b0, 1'b0, 8'd0, 8'd0, ncm1, nrm1);
            ne = 2'd1;
          end else y = y - 9'd1;
        end
        ate_pkg::CH_FF: begin
          es[0] = ate_pkg::mk_slot(ate_pkg::CMD_CLEAR, clr_n, ate_pkg::CH_SPACE, 1'b0,
                                   1'b0, 1'b0, 8'd0, 8'd0, ncm1, nrm1);
          ne = 2'd1;
          x = '0;
          y = '0;
        end
        ate_pkg::CH_CR: x = '0;
        default: ok = 1'b0;
      endcase
      if (ok) begin
        if (y >= {1'b0, nr}) begin
          y = {1'b0, nrm1};
          es[0] = ate_pkg::mk_slot(ate_pkg::CMD_SCROLL_UP, clr_n, ate_pkg::CH_SPACE, 1'b0,
                                   1'b0, 1'b0, 8'd0, 8'd0, ncm1, nrm1);
          ne = 2'd1;
        end
        cx = x[7:0];
        cy = y[7:0];
        wr_n = 1'b0;
      end
    end

    if (cx >= nc) begin
      cx = ncm1;
      wr_n = 1'b0;
    end
    if (cy >= nr) cy = nrm1;
  end

  // one attribute code per step
  logic [7:0] sg_color;
  logic [5:0] sg_flags;
  always_comb begin
    logic [PW-1:0] a;
    logic [3:0] c;
    logic in30, in40, in90, in100, fg, bg;
    a = rd;
    in30 = (a >= PW'(30)) && (a <= PW'(37));
    in40 = (a >= PW'(40)) && (a <= PW'(47));
    in90 = (a >= PW'(90)) && (a <= PW'(97));
    in100 = (a >= PW'(100)) && (a <= PW'(107));
    fg = in30 || in90 || (a == PW'(39));
    bg = in40 || in100 || (a == PW'(49));
    c = '0;
    if (a == PW'(39)) c = defc[3:0];
    else if (a == PW'(49)) c = defc[7:4];
    else if (in30) c = 4'(a - PW'(30));
    else if (in40) c = 4'(a - PW'(40));
    else if (in90) c = 4'(a - PW'(90));
    else if (in100) c = 4'(a - PW'(100));
    if (!c[3]) begin
      if (in90 || in100 || flags[ate_pkg::FL_BRIGHT]) c[3] = 1'b1;
    end
    if (c[3] && flags[ate_pkg::FL_DIM]) c[3] = 1'b0;
    sg_color = color;
    sg_flags = flags;
    if (a == PW'(0)) begin
      sg_flags[ate_pkg::FL_BRIGHT] = 1'b0;
      sg_flags[ate_pkg::FL_DIM] = 1'b0;
      sg_flags[ate_pkg::FL_PASS] = 1'b0;
      sg_color = defc;
    end else if (a == PW'(1)) begin
      sg_color[3] = 1'b1;
      sg_flags[ate_pkg::FL_DIM] = 1'b0;
      sg_flags[ate_pkg::FL_BRIGHT] = 1'b1;
    end else if (a == PW'(2)) begin
      sg_color[3] = 1'b0;
      sg_flags[ate_pkg::FL_BRIGHT] = 1'b0;
      sg_flags[ate_pkg::FL_DIM] = 1'b1;
    end else if (a == PW'(7)) sg_color = {color[3:0], color[7:4]};
    else if (a == PW'(8)) sg_flags[ate_pkg::FL_PASS] = 1'b1;
    else if (fg) sg_color[3:0] = c;
    else if (bg) sg_color[7:4] = c;
  end

  // address unit: base + y * columns + x over two steps
  ate_pkg::slot_t jsl;
  logic [7:0] jx, jy;
  logic [15:0] jaddr;
  assign jsl = slots[ctl.job[1]];
  assign jx = ctl.job[0] ? jsl.ex : jsl.sx;
  assign jy = ctl.job[0] ? jsl.ey : jsl.sy;
  assign jaddr = base + prod + {8'b0, jx};

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= 8'd80;
      rows <= 7'd30;
      base <= '0;
      defc <= 8'd2;
      pmode <= ate_pkg::PM_NORMAL;
      col <= '0;
      row <= '0;
      wrap <= 1'b0;
      scol <= '0;
      srow <= '0;
      swrap <= 1'b0;
      color <= 8'd2;
      flags <= '0;
      pcount <= '0;
      inter <= '0;
      nres <= '0;
      sgr_pend <= 1'b0;
      sgr_i <= '0;
      sgr_n <= '0;
      for (int i = 0; i < ate_pkg::MAX_PARAMS; i++) params[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ate_pkg::CFG_COLUMNS: cols <= cfg_data[7:0];
        ate_pkg::CFG_ROWS:    rows <= cfg_data[6:0];
        ate_pkg::CFG_BASE:    base <= cfg_data;
        ate_pkg::CFG_COLOR:   defc <= cfg_data[7:0];
      endcase
      col <= c_col;
      row <= c_row;
      wrap <= c_wrap;
    end else if (ctl.exec) begin
      pmode <= pm_n;
      col <= cx;
      row <= cy;
      wrap <= wr_n;
      scol <= sc_n;
      srow <= sr_n;
      swrap <= sw_n;
      color <= clr_n;
      flags <= fl_n;
      inter <= ib_n;
      pcount <= pc_n;
      nres <= ne;
      sgr_pend <= sgr_go;
      sgr_i <= '0;
      sgr_n <= (pcount == '0) ? PIW'(1) : pcount;
      if (pclr) begin
        for (int i = 0; i < ate_pkg::MAX_PARAMS; i++) params[i] <= '0;
      end else if (pwe) params[pidx] <= pval;
    end else if (ctl.sgr_step) begin
      color <= sg_color;
      flags <= sg_flags;
      sgr_i <= sgr_i + PIW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      slots[0] <= es[0];
      slots[1] <= es[1];
    end
    if (ctl.mul) prod <= {8'b0, jy} * {8'b0, nc};
    if (ctl.add) begin
      if (ctl.job[0]) addr_e[ctl.job[1]] <= jaddr;
      else addr_s[ctl.job[1]] <= jaddr;
    end
  end

  assign sts.nres = nres;
  assign sts.sgr = sgr_pend;
  assign sts.sgr_last = (sgr_i == sgr_n - PIW'(1));

  ate_pkg::slot_t osl;
  logic [15:0] os, oe;
  logic        oswap;
  assign osl = slots[ctl.send_idx];
  assign os = addr_s[ctl.send_idx];
  assign oe = addr_e[ctl.send_idx];
  assign oswap = osl.swap && (os > oe);
  assign command = osl.cmd;
  assign range_start = osl.zaddr ? 16'd0 : (oswap ? oe : os);
  assign range_end = osl.zaddr ? 16'd0 : (oswap ? os : oe);
  assign cell_color = osl.color;
  assign cell_char = osl.chr;
  assign small_font = osl.font;
  assign wide_columns = osl.wide;
  assign cursor_x = col;
  assign cursor_y = row;
  assign cursor_hidden = flags[ate_pkg::FL_HIDE];

endmodule

// ===== src/ansi_escape_terminal_engine.sv =====
// top level of the terminal escape engine: byte stream in, text memory commands out
//
//   channel   dir  data                                          handshake
//   s_*       in   tdata[7:0] in_byte                            tvalid/tready
//   m_*       out  tdata command..cursor_hidden, tlast last      tvalid/tready
//   cfg_*     in   cfg_index register, cfg_data value            cfg_we, no wait
//
// an item with no result ends after decide; a result takes a multiply and an add step
// per address, then a transfer; an attribute sequence steps per parameter (at least one)
// the shared 8x8 address multiplier is used once per address, twice per result
// synchronous reset; no clearing pass, the block takes a byte in the cycle after reset
// a stalled result holds the block; the next byte is taken once all transfers are done
module ansi_escape_terminal_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // in_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // command, range_start, range_end, cell_color, cell_char, small_font,
  // wide_columns, cursor_x, cursor_y, cursor_hidden, zero fill
  output logic [ate_pkg::TDATA_W-1:0] m_tdata,
  output logic                        m_tlast,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);

  ate_pkg::ctl_t ctl;
  ate_pkg::sts_t sts;
  logic [2:0]  command;
  logic [15:0] range_start, range_end;
  logic [7:0]  cell_color, cell_char, cursor_x, cursor_y;
  logic        small_font, wide_columns, cursor_hidden;

  ate_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_last  (m_tlast),
    .sts       (sts),
    .ctl       (ctl)
  );

  ate_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_byte       (s_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .ctl           (ctl),
    .sts           (sts),
    .command       (command),
    .range_start   (range_start),
    .range_end     (range_end),
    .cell_color    (cell_color),
    .cell_char     (cell_char),
    .small_font    (small_font),
    .wide_columns  (wide_columns),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .cursor_hidden (cursor_hidden)
  );

  assign m_tdata = {2'b00, cursor_hidden, cursor_y, cursor_x, wide_columns, small_font,
                    cell_char, cell_color, range_end, range_start, command};

endmodule
